FILE: sv/packed_operand_chain_alu_macros.svh
// Assertion helpers for the packed operand chain ALU.
`ifndef PACKED_OPERAND_CHAIN_ALU_MACROS_SVH
`define PACKED_OPERAND_CHAIN_ALU_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define POCA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("poca assertion failed");

// Next-cycle implication, checked outside reset.
`define POCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("poca assertion failed");

`endif

FILE: sv/poca_pkg.sv
`default_nettype none
package poca_pkg;

  localparam int unsigned StoreDepth = 9;
  localparam int unsigned AddrW      = 4;
  localparam int unsigned WordBits   = 16;

  // Operation codes.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Word modes.
  localparam logic MODE_INSTR   = 1'b0;
  localparam logic MODE_OPERAND = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] word_value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] chain_result;
    logic               divide_by_zero;
  } res_t;

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [31:0] mag;
    logic [15:0] divisor;
  } div_req_t;

  typedef enum logic [5:0] {
    S_COLLECT = 6'b000001,
    S_FETCH   = 6'b000010,
    S_LOAD    = 6'b000100,
    S_EXEC    = 6'b001000,
    S_DIVW    = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  // Operand words needed for (nm1+2) operands of (dm1+1) bits.
  function automatic logic [3:0] words_needed(input logic [2:0] nm1, input logic [3:0] dm1);
    logic [7:0] bits;
    logic [8:0] sum;
    bits = 8'({4'd0, nm1} + 4'd2) * 8'({3'd0, dm1} + 5'd1);
    sum  = {1'b0, bits} + 9'd15;
    return sum[7:4];
  endfunction

endpackage
`default_nettype wire

FILE: sv/poca_store.sv
`default_nettype none
module poca_store (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [poca_pkg::AddrW-1:0]       wr_addr,
  input  wire logic [poca_pkg::WordBits-1:0]    wr_data,
  input  wire logic [poca_pkg::AddrW-1:0]       rd_addr0,
  input  wire logic [poca_pkg::AddrW-1:0]       rd_addr1,
  output logic      [poca_pkg::WordBits-1:0]    rd_data0,
  output logic      [poca_pkg::WordBits-1:0]    rd_data1
);

  logic [poca_pkg::WordBits-1:0] mem [poca_pkg::StoreDepth];

  // Write one word.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read two words, registered.
  always_ff @(posedge clk) begin
    rd_data0 <= mem[rd_addr0];
    rd_data1 <= mem[rd_addr1];
  end

endmodule
`default_nettype wire

FILE: sv/poca_div.sv
`default_nettype none
module poca_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire poca_pkg::div_req_t req,
  output logic                    busy,
  output logic                    done,
  output logic [31:0]             quotient
);

  logic [31:0] dvd;
  logic [15:0] rem;
  logic [15:0] dvs;
  logic        neg;
  logic [4:0]  cnt;
  logic [16:0] trial;
  logic [16:0] diff;

  // One quotient bit per cycle.
  always_comb begin
    trial = {rem, dvd[31]};
    diff  = trial - {1'b0, dvs};
  end

  assign quotient = neg ? (32'd0 - dvd) : dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvd  <= req.mag;
        dvs  <= req.divisor;
        neg  <= req.neg;
      end else if (busy) begin
        if (!diff[16]) begin
          rem <= diff[15:0];
          dvd <= {dvd[30:0], 1'b1};
        end else begin
          rem <= trial[15:0];
          dvd <= {dvd[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/packed_operand_chain_alu.sv
// Packed operand chain ALU. An instruction word (mode 0) sets the operation
// count N, N two-bit operation codes and the operand width D; the block then
// takes ceil((N+1)*D/16) operand words (mode 1), stores them in a nine-word
// memory, and walks the chain left to right in signed 32-bit arithmetic,
// emitting one result with a divide-by-zero flag. Input words are taken in
// one cycle each while collecting. After the last operand word the chain runs
// from the word memory in three steps per operand (read, extract, execute),
// and each divide waits for the shared bit-serial divider to finish. No input
// is taken during that run.
`default_nettype none
`include "packed_operand_chain_alu_macros.svh"
module packed_operand_chain_alu (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire poca_pkg::cmd_t cmd,
  output logic                res_valid,
  input  wire logic           res_stall,
  output poca_pkg::res_t      res
);

  poca_pkg::state_t state;
  logic [2:0]  nm1;
  logic [3:0]  dm1;
  logic [15:0] ops;
  logic [3:0]  needed;
  logic [3:0]  wcnt;
  logic [3:0]  k;
  logic [7:0]  pos;
  logic [31:0] acc;
  logic        dz;
  logic [15:0] opnd;

  logic        cmd_acc;
  logic [3:0]  rd_addr0;
  logic [3:0]  rd_addr1;
  logic [15:0] rd_data0;
  logic [15:0] rd_data1;
  logic [31:0] cat_sh;
  logic [15:0] opnd_next;
  logic [31:0] prod;
  logic        st_wr;
  logic        div_busy;
  logic        div_done;
  logic [31:0] div_q;
  logic        step_done;
  logic [31:0] step_acc;
  logic        last;
  poca_pkg::div_req_t div_req;

  assign cmd_stall = (state != poca_pkg::S_COLLECT);
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign st_wr     = cmd_acc && (cmd.mode == poca_pkg::MODE_OPERAND) && (wcnt != needed)
                     && (needed != 4'd0);

  // Operand straddles at most two words.
  assign rd_addr0 = pos[7:4];
  assign rd_addr1 = (pos[7:4] == 4'(poca_pkg::StoreDepth - 1)) ? pos[7:4] : pos[7:4] + 4'd1;

  poca_store u_store (
    .clk      (clk),
    .wr_en    (st_wr),
    .wr_addr  (wcnt),
    .wr_data  (cmd.word_value[15:0]),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  // Extract the D-bit operand at the current bit position.
  always_comb begin
    cat_sh    = {rd_data0, rd_data1} << pos[3:0];
    opnd_next = cat_sh[31:16] >> (~dm1);
    prod      = acc * {16'd0, opnd};
  end

  // Launch a divide from the execute state.
  always_comb begin
    div_req.start   = (state == poca_pkg::S_EXEC) && (k != 4'd0) &&
                      (ops[15:14] == poca_pkg::OP_DIV) && (opnd != 16'd0);
    div_req.neg     = acc[31];
    div_req.mag     = acc[31] ? (32'd0 - acc) : acc;
    div_req.divisor = opnd;
  end

  poca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Result of the current step.
  always_comb begin
    step_done = 1'b0;
    step_acc  = acc;
    if (state == poca_pkg::S_EXEC) begin
      if (k == 4'd0) begin
        step_done = 1'b1;
        step_acc  = {16'd0, opnd};
      end else begin
        case (ops[15:14])
          poca_pkg::OP_ADD: begin
            step_done = 1'b1;
            step_acc  = acc + {16'd0, opnd};
          end
          poca_pkg::OP_SUB: begin
            step_done = 1'b1;
            step_acc  = acc - {16'd0, opnd};
          end
          poca_pkg::OP_MUL: begin
            step_done = 1'b1;
            step_acc  = prod;
          end
          default: begin
            step_done = (opnd == 16'd0);
            step_acc  = 32'd0;
          end
        endcase
      end
    end else if (state == poca_pkg::S_DIVW && div_done) begin
      step_done = 1'b1;
      step_acc  = div_q;
    end
  end

  assign last = (k == ({1'b0, nm1} + 4'd1));

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= poca_pkg::S_COLLECT;
      wcnt      <= '0;
      needed    <= '0;
      res_valid <= 1'b0;
    end else begin
      // Drop an accepted word unless a new one replaces it.
      if (res_valid && !res_stall && state != poca_pkg::S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        poca_pkg::S_COLLECT: begin
          if (cmd_acc) begin
            if (cmd.mode == poca_pkg::MODE_INSTR) begin
              nm1    <= cmd.word_value[31:29];
              dm1    <= 4'((cmd.word_value >> (5'd23 - {1'b0, cmd.word_value[31:29], 1'b0})));
              ops    <= cmd.word_value[28:13];
              needed <= poca_pkg::words_needed(cmd.word_value[31:29],
                          4'((cmd.word_value >> (5'd23 - {1'b0, cmd.word_value[31:29], 1'b0}))));
              wcnt   <= '0;
            end else if (st_wr) begin
              if (wcnt + 4'd1 == needed) begin
                needed <= '0;
                wcnt   <= '0;
                k      <= '0;
                pos    <= '0;
                dz     <= 1'b0;
                state  <= poca_pkg::S_FETCH;
              end else begin
                wcnt <= wcnt + 4'd1;
              end
            end
          end
        end
        poca_pkg::S_FETCH: begin
          state <= poca_pkg::S_LOAD;
        end
        poca_pkg::S_LOAD: begin
          opnd  <= opnd_next;
          state <= poca_pkg::S_EXEC;
        end
        poca_pkg::S_EXEC, poca_pkg::S_DIVW: begin
          if (state == poca_pkg::S_EXEC && k != 4'd0 && ops[15:14] == poca_pkg::OP_DIV &&
              opnd == 16'd0) begin
            dz <= 1'b1;
          end
          if (div_req.start) begin
            state <= poca_pkg::S_DIVW;
          end
          if (step_done) begin
            acc <= step_acc;
            if (k != 4'd0) begin
              ops <= {ops[13:0], 2'b00};
            end
            if (last) begin
              state <= poca_pkg::S_DONE;
            end else begin
              k     <= k + 4'd1;
              pos   <= pos + {4'd0, dm1} + 8'd1;
              state <= poca_pkg::S_FETCH;
            end
          end
        end
        poca_pkg::S_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid          <= 1'b1;
            res.chain_result   <= dz ? 32'sd0 : $signed(acc);
            res.divide_by_zero <= dz;
            state              <= poca_pkg::S_COLLECT;
          end
        end
        default: begin
          state <= poca_pkg::S_COLLECT;
        end
      endcase
    end
  end

  `POCA_ASSERT_NOW(a_dz_zero, res_valid && res.divide_by_zero, res.chain_result == 32'sd0)
  `POCA_ASSERT_NOW(a_div_state, div_busy, state == poca_pkg::S_DIVW)
  `POCA_ASSERT_NOW(a_wcnt_range, state == poca_pkg::S_COLLECT, wcnt < 4'(poca_pkg::StoreDepth))
  `POCA_ASSERT_NEXT(a_start_div, div_req.start, div_busy)

endmodule
`default_nettype wire
